// ===== rtl/ac_pkg.sv =====
package ac_pkg;

    localparam int NODE_W    = 12;
    localparam int CNT_W     = NODE_W + 1;
    localparam int SYM_W     = 5;
    localparam int ADDR_W    = NODE_W + SYM_W;
    localparam int END_W     = 16;
    localparam int TOTAL_W   = 32;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int ALPHA     = 26;

    localparam logic [CNT_W-1:0] MAX_NODES_C = CNT_W'(MAX_NODES);
    localparam logic [SYM_W-1:0] ALPHA_C     = SYM_W'(ALPHA);
    localparam logic [SYM_W-1:0] ALPHA_LAST  = SYM_W'(ALPHA - 1);

    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_TEXT    = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_LATE    = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] match_count;
        logic [1:0]         status;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_CLR_ROW,
        OP_SET_LATE,
        OP_SET_BAD,
        OP_RD_GOTO_CUR,
        OP_SET_CUR,
        OP_SET_DROP,
        OP_ALLOC,
        OP_RD_END,
        OP_PAT_END,
        OP_END_INC,
        OP_BUILD_INIT,
        OP_RD_GOTO_ROOT,
        OP_ROOT_CHK,
        OP_BUILD_DONE,
        OP_RD_QUEUE,
        OP_SET_NOW,
        OP_SET_F,
        OP_RD_GOTO_NOW,
        OP_RD_GOTO_F,
        OP_BUILD_UPD,
        OP_CUR_ROOT,
        OP_CUR_MOVE,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       built;
        logic       bad;
        logic       sym_ok;
        logic       last;
        logic       gd_zero;
        logic       full;
        logic       cnt_last;
        logic       q_empty;
        logic       walk_go;
        logic       cur_root;
    } status_t;

    typedef enum logic [19:0] {
        S_IDLE       = 20'h00001,
        S_CLEAR      = 20'h00002,
        S_DISPATCH   = 20'h00004,
        S_P_CHK      = 20'h00008,
        S_P_ROWCLR   = 20'h00010,
        S_P_LAST     = 20'h00020,
        S_P_INC      = 20'h00040,
        S_B_ROOT_RD  = 20'h00080,
        S_B_ROOT_CHK = 20'h00100,
        S_B_POP      = 20'h00200,
        S_B_NOW      = 20'h00400,
        S_B_F        = 20'h00800,
        S_B_RD_C     = 20'h01000,
        S_B_RD_V     = 20'h02000,
        S_B_UPD      = 20'h04000,
        S_T_STEP     = 20'h08000,
        S_T_MOVE     = 20'h10000,
        S_T_WALK     = 20'h20000,
        S_T_ACC      = 20'h40000,
        S_T_END      = 20'h80000
    } state_t;

endpackage

// ===== rtl/ac_ctrl.sv =====
module ac_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ac_pkg::status_t  stat,
    output ac_pkg::op_t      op,
    output logic             busy
);

    ac_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ac_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ac_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = ac_pkg::OP_NONE;
        case (state_reg)
            ac_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op         = ac_pkg::OP_LOAD;
                    state_next = ac_pkg::S_DISPATCH;
                end
            end
            ac_pkg::S_CLEAR:
            begin
                op = ac_pkg::OP_CLR_ROW;
                if (stat.cnt_last)
                begin
                    state_next = ac_pkg::S_IDLE;
                end
            end
            ac_pkg::S_DISPATCH:
            begin
                case (stat.mode)
                    ac_pkg::MODE_CLEAR:
                    begin
                        op         = ac_pkg::OP_CLEAR;
                        state_next = ac_pkg::S_CLEAR;
                    end
                    ac_pkg::MODE_PATTERN:
                    begin
                        if (stat.built)
                        begin
                            op         = ac_pkg::OP_SET_LATE;
                            state_next = ac_pkg::S_IDLE;
                        end
                        else if (stat.bad)
                        begin
                            state_next = ac_pkg::S_P_LAST;
                        end
                        else if (!stat.sym_ok)
                        begin
                            op         = ac_pkg::OP_SET_BAD;
                            state_next = ac_pkg::S_P_LAST;
                        end
                        else
                        begin
                            op         = ac_pkg::OP_RD_GOTO_CUR;
                            state_next = ac_pkg::S_P_CHK;
                        end
                    end
                    ac_pkg::MODE_TEXT:
                    begin
                        if (stat.built)
                        begin
                            state_next = ac_pkg::S_T_STEP;
                        end
                        else
                        begin
                            op         = ac_pkg::OP_BUILD_INIT;
                            state_next = ac_pkg::S_B_ROOT_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ac_pkg::S_IDLE;
                    end
                endcase
            end
            ac_pkg::S_P_CHK:
            begin
                state_next = ac_pkg::S_P_LAST;
                if (!stat.gd_zero)
                begin
                    op = ac_pkg::OP_SET_CUR;
                end
                else if (stat.full)
                begin
                    op = ac_pkg::OP_SET_DROP;
                end
                else
                begin
                    op         = ac_pkg::OP_ALLOC;
                    state_next = ac_pkg::S_P_ROWCLR;
                end
            end
            ac_pkg::S_P_ROWCLR:
            begin
                op = ac_pkg::OP_CLR_ROW;
                if (stat.cnt_last)
                begin
                    state_next = ac_pkg::S_P_LAST;
                end
            end
            ac_pkg::S_P_LAST:
            begin
                state_next = ac_pkg::S_IDLE;
                if (stat.last)
                begin
                    if (!stat.bad && !stat.cur_root)
                    begin
                        op         = ac_pkg::OP_RD_END;
                        state_next = ac_pkg::S_P_INC;
                    end
                    else
                    begin
                        op = ac_pkg::OP_PAT_END;
                    end
                end
            end
            ac_pkg::S_P_INC:
            begin
                op         = ac_pkg::OP_END_INC;
                state_next = ac_pkg::S_IDLE;
            end
            ac_pkg::S_B_ROOT_RD:
            begin
                op         = ac_pkg::OP_RD_GOTO_ROOT;
                state_next = ac_pkg::S_B_ROOT_CHK;
            end
            ac_pkg::S_B_ROOT_CHK:
            begin
                op         = ac_pkg::OP_ROOT_CHK;
                state_next = stat.cnt_last ? ac_pkg::S_B_POP : ac_pkg::S_B_ROOT_RD;
            end
            ac_pkg::S_B_POP:
            begin
                if (stat.q_empty)
                begin
                    op         = ac_pkg::OP_BUILD_DONE;
                    state_next = ac_pkg::S_T_STEP;
                end
                else
                begin
                    op         = ac_pkg::OP_RD_QUEUE;
                    state_next = ac_pkg::S_B_NOW;
                end
            end
            ac_pkg::S_B_NOW:
            begin
                op         = ac_pkg::OP_SET_NOW;
                state_next = ac_pkg::S_B_F;
            end
            ac_pkg::S_B_F:
            begin
                op         = ac_pkg::OP_SET_F;
                state_next = ac_pkg::S_B_RD_C;
            end
            ac_pkg::S_B_RD_C:
            begin
                op         = ac_pkg::OP_RD_GOTO_NOW;
                state_next = ac_pkg::S_B_RD_V;
            end
            ac_pkg::S_B_RD_V:
            begin
                op         = ac_pkg::OP_RD_GOTO_F;
                state_next = ac_pkg::S_B_UPD;
            end
            ac_pkg::S_B_UPD:
            begin
                op         = ac_pkg::OP_BUILD_UPD;
                state_next = stat.cnt_last ? ac_pkg::S_B_POP : ac_pkg::S_B_RD_C;
            end
            ac_pkg::S_T_STEP:
            begin
                if (stat.sym_ok)
                begin
                    op         = ac_pkg::OP_RD_GOTO_CUR;
                    state_next = ac_pkg::S_T_MOVE;
                end
                else
                begin
                    op         = ac_pkg::OP_CUR_ROOT;
                    state_next = ac_pkg::S_T_WALK;
                end
            end
            ac_pkg::S_T_MOVE:
            begin
                op         = ac_pkg::OP_CUR_MOVE;
                state_next = ac_pkg::S_T_WALK;
            end
            ac_pkg::S_T_WALK:
            begin
                state_next = stat.walk_go ? ac_pkg::S_T_ACC : ac_pkg::S_T_END;
            end
            ac_pkg::S_T_ACC:
            begin
                op         = ac_pkg::OP_ACC;
                state_next = ac_pkg::S_T_WALK;
            end
            ac_pkg::S_T_END:
            begin
                if (stat.last)
                begin
                    op = ac_pkg::OP_EMIT;
                end
                state_next = ac_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ac_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ac_datapath.sv =====
module ac_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ac_pkg::item_t     item,
    input  ac_pkg::op_t       op,
    output ac_pkg::status_t   stat,
    output ac_pkg::result_t   result,
    output logic              strobe
);

    localparam int NW = ac_pkg::NODE_W;
    localparam int CW = ac_pkg::CNT_W;
    localparam int SW = ac_pkg::SYM_W;
    localparam int AW = ac_pkg::ADDR_W;
    localparam int EW = ac_pkg::END_W;
    localparam int TW = ac_pkg::TOTAL_W;

    logic [NW-1:0] goto_mem  [1 << AW];
    logic [NW-1:0] fail_mem  [1 << NW];
    logic [EW-1:0] end_mem   [1 << NW];
    logic [NW-1:0] queue_mem [1 << NW];

    ac_pkg::item_t   item_reg;
    ac_pkg::result_t result_reg;
    logic            strobe_reg;
    logic [CW-1:0]   nodes_reg, head_reg, tail_reg, steps_reg;
    logic [NW-1:0]   cursor_reg, c_reg, now_reg, f_reg, t_reg;
    logic [TW-1:0]   total_reg;
    logic            built_reg, bad_reg;
    logic [1:0]      err_reg;
    logic [SW-1:0]   cnt_reg;
    logic [NW-1:0]   gd_reg, fd_reg, qd_reg;
    logic [EW-1:0]   ed_reg;

    logic            goto_we, fail_we, end_we, queue_we;
    logic [AW-1:0]   goto_waddr, goto_raddr;
    logic [NW-1:0]   goto_wdata, fail_waddr, fail_wdata, fail_raddr, end_addr, end_raddr;
    logic [EW-1:0]   end_wdata;
    logic [NW-1:0]   queue_wdata;
    logic            tail_ok;
    logic [TW:0]     sum;
    logic [NW-1:0]   moved;

    assign tail_ok = (tail_reg < ac_pkg::MAX_NODES_C);
    assign sum     = {1'b0, total_reg} + {{(TW + 1 - EW){1'b0}}, ed_reg};
    assign moved   = ({1'b0, gd_reg} >= nodes_reg) ? '0 : gd_reg;

    always_comb
    begin
        goto_we     = 1'b0;
        goto_waddr  = {c_reg, cnt_reg};
        goto_wdata  = '0;
        goto_raddr  = {cursor_reg, item_reg.symbol};
        fail_we     = 1'b0;
        fail_waddr  = gd_reg;
        fail_wdata  = '0;
        fail_raddr  = t_reg;
        end_we      = 1'b0;
        end_addr    = nodes_reg[NW-1:0];
        end_wdata   = '0;
        end_raddr   = t_reg;
        queue_we    = 1'b0;
        queue_wdata = gd_reg;
        case (op)
            ac_pkg::OP_CLR_ROW:
            begin
                goto_we = 1'b1;
            end
            ac_pkg::OP_ALLOC:
            begin
                goto_we    = 1'b1;
                goto_waddr = {cursor_reg, item_reg.symbol};
                goto_wdata = nodes_reg[NW-1:0];
                fail_we    = 1'b1;
                fail_waddr = nodes_reg[NW-1:0];
                end_we     = 1'b1;
            end
            ac_pkg::OP_RD_END:
            begin
                end_raddr = cursor_reg;
            end
            ac_pkg::OP_END_INC:
            begin
                end_we    = (ed_reg != '1);
                end_addr  = cursor_reg;
                end_wdata = ed_reg + 1'b1;
            end
            ac_pkg::OP_RD_GOTO_ROOT:
            begin
                goto_raddr = {{NW{1'b0}}, cnt_reg};
            end
            ac_pkg::OP_ROOT_CHK:
            begin
                fail_we  = (gd_reg != '0) && tail_ok;
                queue_we = (gd_reg != '0) && tail_ok;
            end
            ac_pkg::OP_SET_NOW:
            begin
                fail_raddr = qd_reg;
            end
            ac_pkg::OP_RD_GOTO_NOW:
            begin
                goto_raddr = {now_reg, cnt_reg};
            end
            ac_pkg::OP_RD_GOTO_F:
            begin
                goto_raddr = {f_reg, cnt_reg};
            end
            ac_pkg::OP_BUILD_UPD:
            begin
                goto_we     = (c_reg == '0);
                goto_waddr  = {now_reg, cnt_reg};
                goto_wdata  = gd_reg;
                fail_we     = (c_reg != '0) && tail_ok;
                fail_waddr  = c_reg;
                fail_wdata  = gd_reg;
                queue_we    = (c_reg != '0) && tail_ok;
                queue_wdata = c_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (goto_we)
        begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        gd_reg <= goto_mem[goto_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fd_reg <= fail_mem[fail_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
        begin
            end_mem[end_addr] <= end_wdata;
        end
        ed_reg <= end_mem[end_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[tail_reg[NW-1:0]] <= queue_wdata;
        end
        qd_reg <= queue_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (op == ac_pkg::OP_LOAD)
        begin
            item_reg <= item;
        end
        if (op == ac_pkg::OP_EMIT)
        begin
            result_reg.match_count <= total_reg;
            result_reg.status      <= err_reg[0] ? ac_pkg::STATUS_DROPPED :
                                      (err_reg[1] ? ac_pkg::STATUS_LATE : ac_pkg::STATUS_OK);
        end
        case (op)
            ac_pkg::OP_SET_NOW:   now_reg <= qd_reg;
            ac_pkg::OP_SET_F:     f_reg   <= fd_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            nodes_reg  <= CW'(1);
            cursor_reg <= '0;
            total_reg  <= '0;
            built_reg  <= 1'b0;
            err_reg    <= '0;
            bad_reg    <= 1'b0;
            cnt_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            steps_reg  <= '0;
            t_reg      <= '0;
            c_reg      <= '0;
        end
        else
        begin
            strobe_reg <= (op == ac_pkg::OP_EMIT);
            case (op)
                ac_pkg::OP_CLEAR:
                begin
                    nodes_reg  <= CW'(1);
                    cursor_reg <= '0;
                    total_reg  <= '0;
                    built_reg  <= 1'b0;
                    err_reg    <= '0;
                    bad_reg    <= 1'b0;
                    cnt_reg    <= '0;
                    c_reg      <= '0;
                end
                ac_pkg::OP_CLR_ROW:  cnt_reg <= cnt_reg + 1'b1;
                ac_pkg::OP_SET_LATE: err_reg[1] <= 1'b1;
                ac_pkg::OP_SET_BAD:  bad_reg <= 1'b1;
                ac_pkg::OP_SET_CUR:  cursor_reg <= gd_reg;
                ac_pkg::OP_SET_DROP:
                begin
                    err_reg[0] <= 1'b1;
                    bad_reg    <= 1'b1;
                end
                ac_pkg::OP_ALLOC:
                begin
                    cursor_reg <= nodes_reg[NW-1:0];
                    nodes_reg  <= nodes_reg + 1'b1;
                    cnt_reg    <= '0;
                    c_reg      <= nodes_reg[NW-1:0];
                end
                ac_pkg::OP_PAT_END, ac_pkg::OP_END_INC:
                begin
                    bad_reg    <= 1'b0;
                    cursor_reg <= '0;
                end
                ac_pkg::OP_BUILD_INIT:
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                    cnt_reg  <= '0;
                end
                ac_pkg::OP_ROOT_CHK:
                begin
                    if ((gd_reg != '0) && tail_ok)
                    begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ac_pkg::OP_BUILD_DONE:
                begin
                    built_reg  <= 1'b1;
                    cursor_reg <= '0;
                    total_reg  <= '0;
                end
                ac_pkg::OP_RD_QUEUE:  head_reg <= head_reg + 1'b1;
                ac_pkg::OP_SET_F:     cnt_reg  <= '0;
                ac_pkg::OP_RD_GOTO_F: c_reg    <= gd_reg;
                ac_pkg::OP_BUILD_UPD:
                begin
                    if ((c_reg != '0) && tail_ok)
                    begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ac_pkg::OP_CUR_ROOT:
                begin
                    cursor_reg <= '0;
                    t_reg      <= '0;
                    steps_reg  <= '0;
                end
                ac_pkg::OP_CUR_MOVE:
                begin
                    cursor_reg <= moved;
                    t_reg      <= moved;
                    steps_reg  <= '0;
                end
                ac_pkg::OP_ACC:
                begin
                    total_reg <= sum[TW] ? '1 : sum[TW-1:0];
                    t_reg     <= fd_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
                ac_pkg::OP_EMIT:
                begin
                    cursor_reg <= '0;
                    total_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        stat.mode     = item_reg.mode;
        stat.built    = built_reg;
        stat.bad      = bad_reg;
        stat.sym_ok   = (item_reg.symbol < ac_pkg::ALPHA_C);
        stat.last     = item_reg.last;
        stat.gd_zero  = (gd_reg == '0);
        stat.full     = (nodes_reg >= ac_pkg::MAX_NODES_C);
        stat.cnt_last = (cnt_reg == ac_pkg::ALPHA_LAST);
        stat.q_empty  = (head_reg == tail_reg);
        stat.walk_go  = (t_reg != '0) && ({1'b0, t_reg} < nodes_reg) && (steps_reg < nodes_reg);
        stat.cur_root = (cursor_reg == '0);
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

// ===== rtl/aho_corasick_match_counter.sv =====
// Channel  Ports                 Transfer
// -------  --------------------  ---------------------------------
// input    item, start, busy     rising edge with start & !busy
// result   result, strobe        rising edge ending the strobe cycle
//
// Pattern character: a late one only sets the late flag, a discarded one skips the
// goto lookup; a new node's row is cleared and a counted pattern end bumps its count.
// Text character: goto read and move (no move for a letter outside the alphabet), then
// an accumulate step per failure-chain node (end count and fail link read together).
// First text character after patterns also runs the build: a read per root entry, then
// per queued node a pop and per goto entry an update, through the single goto port.
// Reset and clear run a pass over every root-row entry; busy stays high meanwhile.
// The result strobe lasts one cycle; the receiver cannot stall it.
module aho_corasick_match_counter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ac_pkg::item_t   item,
    output ac_pkg::result_t result,
    output logic            strobe
);

    ac_pkg::op_t     op;
    ac_pkg::status_t stat;

    ac_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    ac_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .op     (op),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

// ===== rtl/ac_checker.sv =====
module ac_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input ac_pkg::item_t   item,
    input ac_pkg::result_t result,
    input logic            strobe
);

    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted without going busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.status <= ac_pkg::STATUS_LATE))
        else $error("undefined status code");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == ac_pkg::MODE_CLEAR) |=> ##1 !strobe)
        else $error("clear produced a result");

endmodule

bind aho_corasick_match_counter ac_checker u_ac_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .strobe (strobe)
);

// ===== sim/aho_corasick_match_counter_tb.sv =====
`timescale 1ns / 1ps

module aho_corasick_match_counter_tb;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 1730;

    localparam int NODE_W    = ac_pkg::NODE_W;
    localparam int END_W     = ac_pkg::END_W;
    localparam int TOTAL_W   = ac_pkg::TOTAL_W;
    localparam int SYM_W     = ac_pkg::SYM_W;
    localparam int MAX_NODES = ac_pkg::MAX_NODES;
    localparam int ALPHA     = ac_pkg::ALPHA;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    ac_pkg::item_t   item;
    ac_pkg::result_t result;
    logic            strobe;

    aho_corasick_match_counter uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    // automaton mirror
    logic [NODE_W-1:0] trie_goto [MAX_NODES*ALPHA];
    logic [NODE_W-1:0] trie_fail [MAX_NODES];
    logic [END_W-1:0]  trie_ends [MAX_NODES];
    logic [NODE_W-1:0] bfs_order [MAX_NODES];
    int unsigned       nodes_used;
    int unsigned       cursor;
    logic [TOTAL_W-1:0] running_total;
    bit                built;
    logic [1:0]        err_flags;
    bit                pattern_bad;

    ac_pkg::result_t expected_counts[$];
    int      errors;
    int      cycles = 0;
    int      burst_left;

    typedef struct {
        ac_pkg::item_t   it;
        bit              typed;
        ac_pkg::result_t res;
    } row_t;

    row_t directed[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    task automatic clear_trie();
        for (int i = 0; i < ALPHA; i++)
            trie_goto[i] = '0;
        trie_ends[0] = '0;
        trie_fail[0] = '0;
        nodes_used = 1;
        cursor = 0;
        running_total = '0;
        built = 0;
        err_flags = '0;
        pattern_bad = 0;
    endtask

    task automatic build_links();
        int unsigned head;
        int unsigned tail;
        int unsigned now;
        int unsigned f;
        int unsigned c;
        logic [NODE_W-1:0] via;
        head = 0;
        tail = 0;
        trie_fail[0] = '0;
        for (int i = 0; i < ALPHA; i++)
        begin
            c = trie_goto[i];
            if (c != 0 && tail < MAX_NODES)
            begin
                trie_fail[c] = '0;
                bfs_order[tail] = NODE_W'(c);
                tail++;
            end
        end
        while (head < tail)
        begin
            now = bfs_order[head];
            head++;
            f = trie_fail[now];
            for (int i = 0; i < ALPHA; i++)
            begin
                c = trie_goto[now*ALPHA + i];
                via = trie_goto[f*ALPHA + i];
                if (c == 0)
                    trie_goto[now*ALPHA + i] = via;
                else if (tail < MAX_NODES)
                begin
                    trie_fail[c] = via;
                    bfs_order[tail] = NODE_W'(c);
                    tail++;
                end
            end
        end
        built = 1;
        cursor = 0;
        running_total = '0;
    endtask

    task automatic add_pattern_char(int unsigned sym, bit last);
        int unsigned slot;
        int unsigned c;
        if (built)
        begin
            err_flags[1] = 1'b1;
            return;
        end
        if (!pattern_bad)
        begin
            if (sym >= ALPHA)
                pattern_bad = 1;
            else
            begin
                slot = cursor*ALPHA + sym;
                c = trie_goto[slot];
                if (c == 0)
                begin
                    if (nodes_used >= MAX_NODES)
                    begin
                        err_flags[0] = 1'b1;
                        pattern_bad = 1;
                    end
                    else
                    begin
                        c = nodes_used;
                        nodes_used++;
                        for (int i = 0; i < ALPHA; i++)
                            trie_goto[c*ALPHA + i] = '0;
                        trie_ends[c] = '0;
                        trie_fail[c] = '0;
                        trie_goto[slot] = NODE_W'(c);
                    end
                end
                if (!pattern_bad)
                    cursor = c;
            end
        end
        if (last)
        begin
            if (!pattern_bad && cursor != 0 && trie_ends[cursor] != 16'hFFFF)
                trie_ends[cursor]++;
            pattern_bad = 0;
            cursor = 0;
        end
    endtask

    task automatic scan_text_char(int unsigned sym, bit last, output bit has,
                                  output ac_pkg::result_t r);
        int unsigned t;
        int unsigned steps;
        longint unsigned sum;
        has = 0;
        r = '0;
        if (!built)
            build_links();
        sum = running_total;
        steps = 0;
        if (sym >= ALPHA)
            cursor = 0;
        else
        begin
            cursor = trie_goto[cursor*ALPHA + sym];
            if (cursor >= nodes_used)
                cursor = 0;
        end
        t = cursor;
        while (t != 0 && t < nodes_used && steps < nodes_used)
        begin
            sum += trie_ends[t];
            t = trie_fail[t];
            steps++;
        end
        running_total = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : TOTAL_W'(sum);
        if (last)
        begin
            has = 1;
            r.match_count = running_total;
            r.status = err_flags[0] ? ac_pkg::STATUS_DROPPED :
                       (err_flags[1] ? ac_pkg::STATUS_LATE : ac_pkg::STATUS_OK);
            cursor = 0;
            running_total = '0;
        end
    endtask

    task automatic predict_item(ac_pkg::item_t it, output bit has, output ac_pkg::result_t r);
        has = 0;
        r = '0;
        case (it.mode)
            ac_pkg::MODE_PATTERN: add_pattern_char(it.symbol, it.last);
            ac_pkg::MODE_TEXT:    scan_text_char(it.symbol, it.last, has, r);
            ac_pkg::MODE_CLEAR:   clear_trie();
            default: ;
        endcase
    endtask

    task automatic send(ac_pkg::item_t it, bit typed, ac_pkg::result_t res);
        bit has;
        ac_pkg::result_t r;
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(it, has, r);
        if (has)
            expected_counts.push_back(typed ? res : r);
    endtask

    task automatic send_item(logic [1:0] mode, int unsigned sym, bit last);
        ac_pkg::item_t it;
        it.mode = mode;
        it.symbol = SYM_W'(sym);
        it.last = last;
        send(it, 1'b0, '0);
    endtask

    task automatic pace();
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    function automatic row_t mk(logic [1:0] mode, int unsigned sym, bit last, bit typed,
                                logic [31:0] cnt, logic [1:0] st);
        row_t row;
        row.it.mode = mode;
        row.it.symbol = SYM_W'(sym);
        row.it.last = last;
        row.typed = typed;
        row.res.match_count = cnt;
        row.res.status = st;
        return row;
    endfunction

    function automatic int unsigned rand_sym(int unsigned span);
        if ($urandom_range(0, 40) == 0)
            return $urandom_range(ALPHA, 31);
        return $urandom_range(0, span - 1);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected result count=%0d status=%0d", $time,
                         result.match_count, result.status);
                errors++;
            end
            else
            begin
                ac_pkg::result_t e;
                e = expected_counts.pop_front();
                if (result.match_count !== e.match_count)
                begin
                    $display("%0t: match_count expected %0d actual %0d", $time,
                             e.match_count, result.match_count);
                    errors++;
                end
                if (result.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, result.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int sent;
        int span;
        int wait_cnt;
        errors = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        for (int i = 0; i < MAX_NODES*ALPHA; i++)
            trie_goto[i] = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            trie_fail[i] = '0;
            trie_ends[i] = '0;
            bfs_order[i] = '0;
        end
        clear_trie();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(mk(ac_pkg::MODE_TEXT, 0, 1'b1, 1'b1, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_CLEAR, 0, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 0, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 0, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 1, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 1, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 31, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 25, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 0, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 0, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 1, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 2, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 2, 1'b1, 1'b1, 32'd0, ac_pkg::STATUS_LATE));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 31, 1'b1, 1'b1, 32'd0, ac_pkg::STATUS_LATE));
        directed.push_back(mk(MODE_UNUSED, 25, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_CLEAR, 31, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 25, 1'b1, 1'b1, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_CLEAR, 0, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_PATTERN, 25, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 25, 1'b0, 1'b0, 32'd0, ac_pkg::STATUS_OK));
        directed.push_back(mk(ac_pkg::MODE_TEXT, 25, 1'b1, 1'b0, 32'd0, ac_pkg::STATUS_OK));

        foreach (directed[i])
        begin
            send(directed[i].it, directed[i].typed, directed[i].res);
            pace();
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            span = $urandom_range(2, 26);
            send_item(ac_pkg::MODE_CLEAR, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
            pace();
            sent++;
            repeat ($urandom_range(1, 8))
            begin
                int len;
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    send_item(ac_pkg::MODE_PATTERN, rand_sym(span), k == len - 1);
                    pace();
                    sent++;
                end
            end
            repeat ($urandom_range(1, 5))
            begin
                int len;
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 30) == 0)
                        send_item(MODE_UNUSED, $urandom_range(0, 31),
                                  1'($urandom_range(0, 1)));
                    else if ($urandom_range(0, 40) == 0)
                        send_item(ac_pkg::MODE_PATTERN, $urandom_range(0, 31),
                                  1'($urandom_range(0, 1)));
                    send_item(ac_pkg::MODE_TEXT, rand_sym(span), k == len - 1);
                    pace();
                    sent++;
                end
            end
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (expected_counts.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_counts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
